@@ design/f32ta_pkg.sv @@
// ----------------------------------------------------------------------------
// f32ta_pkg
// Shared types and constants for the truncating single-precision adder.
// ----------------------------------------------------------------------------
`default_nettype none
package f32ta_pkg;
    localparam int unsigned WordWidth = 32;
    localparam int unsigned ExpWidth  = 8;
    localparam int unsigned FracWidth = 23;
    localparam int unsigned MantWidth = 24;
    localparam int unsigned ShiftWidth = 5;
    localparam logic [ExpWidth-1:0] ExpMax = 8'hFF;

    typedef struct packed {
        logic                 bypass;
        logic [WordWidth-1:0] bypass_bits;
        logic                 sign_a;
        logic                 sign_b;
        logic [ExpWidth-1:0]  expo;
        logic [MantWidth-1:0] mant_a;
        logic [MantWidth-1:0] mant_b;
    } align_t;

    typedef struct packed {
        logic                 bypass;
        logic [WordWidth-1:0] bypass_bits;
        logic                 sign;
        logic                 same;
        logic [ExpWidth-1:0]  expo;
        logic [MantWidth:0]   mant;
    } sum_t;
endpackage
`default_nettype wire

@@ design/f32ta_align.sv @@
// ----------------------------------------------------------------------------
// f32ta_align
// Unpack operands, detect zero bypass, align the significand with the smaller exponent.
// ----------------------------------------------------------------------------
`default_nettype none
module f32ta_align (
    input  wire logic [31:0]        a,
    input  wire logic [31:0]        b,
    output f32ta_pkg::align_t       q
);
    logic [7:0]  ea, eb, d;
    logic [23:0] ma, mb;
    logic        a_lt;
    always_comb begin
        ea = a[30:23];
        eb = b[30:23];
        ma = {1'b1, a[22:0]};
        mb = {1'b1, b[22:0]};
        a_lt = ea < eb;
        d = a_lt ? (eb - ea) : (ea - eb);
        q.bypass = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
        q.bypass_bits = (a[30:0] == 31'd0) ? b : a;
        q.sign_a = a[31];
        q.sign_b = b[31];
        q.expo = a_lt ? eb : ea;
        q.mant_a = ma;
        q.mant_b = mb;
        if (a_lt) begin
            q.mant_a = (d >= 8'd24) ? 24'd0 : (ma >> d[4:0]);
        end else begin
            q.mant_b = (d >= 8'd24) ? 24'd0 : (mb >> d[4:0]);
        end
    end
endmodule
`default_nettype wire

@@ design/f32ta_addsub.sv @@
// ----------------------------------------------------------------------------
// f32ta_addsub
// Add or subtract the aligned significands, larger magnitude first.
// ----------------------------------------------------------------------------
`default_nettype none
module f32ta_addsub (
    input  f32ta_pkg::align_t d,
    output f32ta_pkg::sum_t   q
);
    always_comb begin
        q.bypass = d.bypass;
        q.bypass_bits = d.bypass_bits;
        q.expo = d.expo;
        q.same = d.sign_a == d.sign_b;
        if (d.sign_a == d.sign_b) begin
            q.sign = d.sign_a;
            q.mant = {1'b0, d.mant_a} + {1'b0, d.mant_b};
        end else if (d.mant_a > d.mant_b) begin
            q.sign = d.sign_a;
            q.mant = {1'b0, d.mant_a - d.mant_b};
        end else if (d.mant_b > d.mant_a) begin
            q.sign = d.sign_b;
            q.mant = {1'b0, d.mant_b - d.mant_a};
        end else begin
            q.sign = 1'b0;
            q.mant = '0;
        end
    end
endmodule
`default_nettype wire

@@ design/f32ta_norm.sv @@
// ----------------------------------------------------------------------------
// f32ta_norm
// Renormalize after carry or cancellation and pack the result.
// ----------------------------------------------------------------------------
`default_nettype none
module f32ta_norm (
    input  f32ta_pkg::sum_t   d,
    output logic [31:0]       sum
);
    logic [4:0]  lz;
    logic [23:0] m;
    logic [8:0]  e_inc;
    always_comb begin
        lz = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (d.mant[i]) lz = 5'(23 - i);
        end
        m = d.mant[23:0] << lz;
        e_inc = {1'b0, d.expo} + 9'd1;
        if (d.bypass) begin
            sum = d.bypass_bits;
        end else if (d.same) begin
            if (d.mant[24]) begin
                if (e_inc >= 9'd255) sum = {d.sign, f32ta_pkg::ExpMax, 23'd0};
                else sum = {d.sign, e_inc[7:0], d.mant[23:1]};
            end else begin
                sum = {d.sign, d.expo, d.mant[22:0]};
            end
        end else if (d.mant == '0) begin
            sum = 32'd0;
        end else if ({3'd0, lz} > d.expo) begin
            sum = {d.sign, 31'd0};
        end else begin
            sum = {d.sign, d.expo - {3'd0, lz}, m[22:0]};
        end
    end
endmodule
`default_nettype wire

@@ design/float32_truncating_adder.sv @@
// ----------------------------------------------------------------------------
// float32_truncating_adder
// Three-stage truncating single-precision adder.
//
//   channel  ports                        direction
//   s_       s_valid s_ready s_operand_*  in
//   m_       m_valid m_ready m_sum_bits   out
//
// One beat per cycle while the output is not stalled; align, add and normalize stages, each registered.
// Reset clears stage valid bits only.
// A stalled output holds the pipe; a bubble stage still accepts a beat.
// ----------------------------------------------------------------------------
`default_nettype none
module float32_truncating_adder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_operand_a,
    input  wire logic [31:0] s_operand_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_sum_bits
);
    f32ta_pkg::align_t al_next, al_reg;
    f32ta_pkg::sum_t   sm_next, sm_reg;
    logic [31:0]       out_next, out_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic en3, en2, en1;

    f32ta_align u_align (.a(s_operand_a), .b(s_operand_b), .q(al_next));
    f32ta_addsub u_addsub (.d(al_reg), .q(sm_next));
    f32ta_norm u_norm (.d(sm_reg), .sum(out_next));

    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v3_reg;
    assign m_sum_bits = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
        if (en1) al_reg <= al_next;
        if (en2) sm_reg <= sm_next;
        if (en3) out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sum_bits))
        else $error("output beat changed under stall");
    a_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && en3 |=> v3_reg)
        else $error("stage two beat lost");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_ready)
        else $error("empty stage refused beat");
`endif
endmodule
`default_nettype wire

@@ tb/float32_truncating_adder_test.sv @@
// ----------------------------------------------------------------------------
// float32_truncating_adder_test
// Drives operand pairs through the truncating single-precision adder and
// compares every sum against a local bit-exact model of the datapath, with
// random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none
module float32_truncating_adder_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PipeDepth = 3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_operand_a = '0;
    logic [31:0] s_operand_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_sum_bits;

    logic [31:0] sum_queue[$];
    int          error_count = 0;
    int          send_idle_pct = 37;
    int          recv_idle_pct = 37;
    int          hold_cycles = 0;

    float32_truncating_adder i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operand_a(s_operand_a),
        .s_operand_b(s_operand_b),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_sum_bits (m_sum_bits)
    );

    always #1 aclk = ~aclk;

    function automatic logic [31:0] truncated_sum(logic [31:0] a, logic [31:0] b);
        logic                            sa, sb, sign;
        logic [f32ta_pkg::ExpWidth-1:0]  ea, eb;
        logic [f32ta_pkg::MantWidth-1:0] ma, mb;
        logic [f32ta_pkg::MantWidth:0]   mant;
        int unsigned                     expo, gap, shifts;
        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        if (a[30:0] == '0) return b;
        if (b[30:0] == '0) return a;
        ma = {1'b1, a[22:0]};
        mb = {1'b1, b[22:0]};
        if (ea < eb) begin
            gap = 32'(eb - ea);
            ma = (gap >= f32ta_pkg::MantWidth) ? '0 : ma >> gap;
            expo = 32'(eb);
        end else begin
            gap = 32'(ea - eb);
            mb = (gap >= f32ta_pkg::MantWidth) ? '0 : mb >> gap;
            expo = 32'(ea);
        end
        if (sa == sb) begin
            mant = {1'b0, ma} + {1'b0, mb};
            if (mant[f32ta_pkg::MantWidth]) begin
                mant = mant >> 1;
                expo++;
                if (expo >= 255) return {sa, f32ta_pkg::ExpMax, 23'd0};
            end
            return {sa, expo[7:0], mant[22:0]};
        end
        if (ma > mb) begin
            sign = sa;
            mant = {1'b0, ma - mb};
        end else if (mb > ma) begin
            sign = sb;
            mant = {1'b0, mb - ma};
        end else begin
            return 32'd0;
        end
        shifts = 0;
        while (!mant[23] && shifts < 24) begin
            mant = mant << 1;
            shifts++;
        end
        if (shifts > expo) return {sign, 31'd0};
        expo -= shifts;
        return {sign, expo[7:0], mant[22:0]};
    endfunction

    task automatic report_mismatch(logic [31:0] got, logic [31:0] want);
        $display("mismatch: sum %h, want %h", got, want);
        error_count++;
    endtask

    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operand_a <= a;
        s_operand_b <= b;
        do @(posedge aclk); while (!s_ready);
        sum_queue.push_back(truncated_sum(a, b));
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
    endtask

    // receiver: random stalls, plus a counted hold-off when requested
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
        if (aresetn && m_valid && m_ready) begin
            if (sum_queue.size() == 0) begin
                report_mismatch(m_sum_bits, 'x);
            end else begin
                if (m_sum_bits !== sum_queue[0]) report_mismatch(m_sum_bits, sum_queue[0]);
                sum_queue.pop_front();
            end
        end
    end

    function automatic logic [31:0] rand_float();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(7))
            0: v[30:23] = 8'($urandom_range(3));
            1: v[30:23] = 8'd255 - 8'($urandom_range(2));
            2: v[30:0] = '0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'h8000_0000, 32'h3F80_0000);
        send_pair(32'hC040_0000, 32'h8000_0000);
        send_pair(32'h3F80_0000, 32'h3F80_0000);
        send_pair(32'h3F80_0000, 32'hBF80_0000);
        send_pair(32'hBF80_0000, 32'h3F80_0000);
        send_pair(32'h4B80_0000, 32'h3F80_0000);
        send_pair(32'h3F80_0000, 32'h4C00_0000);
        send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);
        send_pair(32'hFF7F_FFFF, 32'hFF00_0000);
        send_pair(32'h7F80_0000, 32'h3F80_0000);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h0080_0000, 32'h8000_0001);
        send_pair(32'h0000_0001, 32'h8000_0002);
        send_pair(32'h0040_0000, 32'h8030_0000);
        send_pair(32'h3F80_0001, 32'hBF80_0000);
        send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_pair(32'h0000_0001, 32'h0000_0001);
        send_pair(32'h0080_0001, 32'h8080_0000);
    endtask

    task automatic test_random();
        logic [31:0] a, b;
        for (int i = 0; i < 1200; i++) begin
            a = rand_float();
            b = rand_float();
            if ($urandom_range(3) == 0) begin
                b[30:23] = a[30:23] + 8'($urandom_range(2)) - 8'd1;
                if ($urandom_range(1)) b[31] = ~a[31];
            end
            send_pair(a, b);
        end
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 60; i++) send_pair(rand_float(), rand_float());
        send_idle_pct = 37;
        recv_idle_pct = 37;
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_cycles = 40;
        for (int i = 0; i < 30; i++) send_pair(rand_float(), rand_float());
        send_idle_pct = 37;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_no_idle();
        test_backpressure();
        test_random();
        stop_sending();
        while (sum_queue.size() != 0) @(posedge aclk);
        repeat (PipeDepth * 10) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
